// ===== src/at_response_ipd_parser_defines.svh =====
// Assertion macros shared by the checker of the IPD response parser.
// Depends on nothing; the asserting file supplies clk and arst_n.
`ifndef AT_RESPONSE_IPD_PARSER_DEFINES_SVH
`define AT_RESPONSE_IPD_PARSER_DEFINES_SVH

// Checked only while out of reset.
`define ATIPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ATIPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/atipd_pkg.sv =====
// Shared types, codes and constants of the IPD response parser.
// Depends on nothing.
package atipd_pkg;

	localparam int LINE_DEPTH_DEF   = 256;
	localparam int CHANNELS_DEF     = 5;
	localparam int HEADER_DEPTH_DEF = 20;
	localparam int NUM_CAP          = 5;
	localparam int QUEUE_DEPTH      = 4;
	localparam int CFG_W            = 16;
	localparam int CFG_IDX_W        = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAP2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAP3    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAP4    = 3'd5;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [15:0] TC_MAX  = 16'hFFFF;
	localparam logic [12:0] BR_MAX  = 13'd8191;
	localparam logic [3:0]  ID_MAX  = 4'd15;
	localparam logic [11:0] LEN_MAX = 12'd4095;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] STAT_NONE = 2'd0;
	localparam logic [1:0] STAT_DONE = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;
	localparam logic [1:0] STAT_TMO  = 2'd3;

	localparam logic [2:0] PH_P    = 3'd0;
	localparam logic [2:0] PH_D    = 3'd1;
	localparam logic [2:0] PH_SEP  = 3'd2;
	localparam logic [2:0] PH_ID0  = 3'd3;
	localparam logic [2:0] PH_ID   = 3'd4;
	localparam logic [2:0] PH_LEN0 = 3'd5;
	localparam logic [2:0] PH_LEN  = 3'd6;
	localparam logic [2:0] PH_BAD  = 3'd7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LINE,
		ST_HEADER,
		ST_PAYLOAD,
		ST_PROMPT
	} state_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic        line_write;
		logic [7:0]  line_index;
		logic [7:0]  line_char;
		logic [1:0]  line_status;
		logic        data_write;
		logic [3:0]  data_channel;
		logic [11:0] data_offset;
		logic [7:0]  data_byte;
		logic [1:0]  data_status;
		logic        send_now;
		logic        last;
	} out_word_t;

	// All results caused by one input word; count runs from one to three.
	typedef struct packed {
		logic [1:0]          count;
		out_word_t [2:0]     res;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} q_head_t;

endpackage

// ===== src/at_response_ipd_parser.sv =====
// Top level of the modem IPD response parser.
// Depends on atipd_pkg, atipd_front, atipd_queue and atipd_back.
//
//  channel   direction  handshake            word
//  in        input      in_valid / in_stall   in_word_t: opcode, rx_byte
//  out       output     out_valid / out_stall out_word_t: line, data and prompt results
//  cfg       input      cfg_write             cfg_index, cfg_data
//
// The front end takes one input word per cycle while the queue has room, and works
// out in that cycle the whole parser update and all results that the word causes
// (one to three). The back end issues one result word per cycle, unless out_stall
// holds it, from a four-entry bundle queue. Most words cause one result; a NUL
// or a header that falls back to a text line causes two or three.
// Reset is asynchronous and clears parser state, the queue and the output valid
// flag, and loads the timeout and capacity registers with their defaults.
// in_stall rises while the queue is full; out_stall holds the output register.
module at_response_ipd_parser #(
	parameter int LINE_DEPTH   = atipd_pkg::LINE_DEPTH_DEF,
	parameter int CHANNELS     = atipd_pkg::CHANNELS_DEF,
	parameter int HEADER_DEPTH = atipd_pkg::HEADER_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  atipd_pkg::in_word_t             in_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output atipd_pkg::out_word_t            out_word,
	input  logic                            cfg_write,
	input  logic [atipd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [atipd_pkg::CFG_W-1:0]     cfg_data
);

	logic               push;
	logic               pop;
	logic               full;
	atipd_pkg::bundle_t bundle;
	atipd_pkg::q_head_t head;

	// A word is taken whenever the queue has room, independent of the output side.
	assign in_stall = full;
	assign push     = in_valid && !full;

	atipd_front #(
		.LINE_DEPTH   (LINE_DEPTH),
		.CHANNELS     (CHANNELS),
		.HEADER_DEPTH (HEADER_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_word   (in_word),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bundle    (bundle)
	);

	atipd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.full      (full),
		.head      (head)
	);

	atipd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== src/atipd_front.sv =====
// Front end: configuration registers, parser state and per-word result bundles.
// Depends on atipd_pkg.
module atipd_front #(
	parameter int LINE_DEPTH   = atipd_pkg::LINE_DEPTH_DEF,
	parameter int CHANNELS     = atipd_pkg::CHANNELS_DEF,
	parameter int HEADER_DEPTH = atipd_pkg::HEADER_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  atipd_pkg::in_word_t             in_word,
	input  logic                            cfg_write,
	input  logic [atipd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [atipd_pkg::CFG_W-1:0]     cfg_data,
	output atipd_pkg::bundle_t              bundle
);

	localparam int POS_W = $clog2(LINE_DEPTH);
	localparam int XW    = POS_W + 8;
	localparam int CNT_W = $clog2(HEADER_DEPTH + 1);
	localparam logic [POS_W:0] LINE_LIM = (POS_W+1)'(LINE_DEPTH);
	localparam logic [CNT_W-1:0] HDR_LIM = CNT_W'(HEADER_DEPTH);
	localparam logic [3:0] CHAN_LIM = 4'(CHANNELS);

	logic [15:0]             tt_q;
	logic [11:0]             cap_q [atipd_pkg::NUM_CAP];
	atipd_pkg::state_t       state_q, state_d;
	logic [2:0]              phase_q, phase_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [3:0]              id_q, id_d;
	logic [11:0]             len_q, len_d;
	logic [12:0]             br_q, br_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic [15:0]             tc_q, tc_d;

	logic [7:0]              c;
	logic                    hdr_restart;
	logic [7:0]              e0, e1;
	logic [1:0]              en;
	logic [7:0]              raw_c [3];
	logic [1:0]              raw_n;
	logic [POS_W-1:0]        wpos;
	logic [XW-1:0]           wext;
	logic                    lw_ok;
	logic [1:0]              lw_n;
	logic                    lw_wr [3];
	logic [7:0]              lw_idx [3];
	logic [7:0]              lw_ch [3];

	logic                    digit;
	logic [7:0]              id_acc;
	logic [15:0]             len_acc;
	logic [2:0]              hp_phase;
	logic [3:0]              hp_id;
	logic [11:0]             hp_len;

	logic [11:0]             cap;
	logic [12:0]             br_inc;
	logic                    pay_keep;
	logic [15:0]             tc_inc;
	logic [CNT_W-1:0]        cnt_inc;

	logic                    use_line;
	logic                    dw;
	logic [1:0]              ls, ds;
	logic                    send;
	logic [1:0]              fin;

	assign c           = in_word.rx_byte;
	assign hdr_restart = (state_q == atipd_pkg::ST_HEADER) && (cnt_q == '0) &&
	                     (c != atipd_pkg::CH_I);

	// Characters to put into the line store, then the writes that fit.
	always_comb begin
		e0 = c;
		e1 = 8'd0;
		en = 2'd1;
		if (c == atipd_pkg::CH_NUL) begin
			e0 = atipd_pkg::CH_BSL;
			e1 = atipd_pkg::CH_ZERO;
			en = 2'd2;
		end else if (c == atipd_pkg::CH_CR || c == atipd_pkg::CH_LF) begin
			en = 2'd0;
		end
		if (hdr_restart) begin
			raw_c[0] = atipd_pkg::CH_PLUS;
			raw_c[1] = e0;
			raw_c[2] = e1;
			raw_n    = en + 2'd1;
			wpos     = '0;
		end else begin
			raw_c[0] = e0;
			raw_c[1] = e1;
			raw_c[2] = 8'd0;
			raw_n    = en;
			wpos     = (state_q == atipd_pkg::ST_IDLE) ? '0 : pos_q;
		end
		lw_ok = 1'b1;
		lw_n  = 2'd0;
		wext  = '0;
		for (int k = 0; k < 3; k++) begin
			lw_wr[k]  = 1'b0;
			lw_idx[k] = 8'd0;
			lw_ch[k]  = 8'd0;
			if ((2'(k) < raw_n) && lw_ok) begin
				if (({1'b0, wpos} + (POS_W+1)'(1)) >= LINE_LIM) begin
					lw_ok = 1'b0;
				end else begin
					wext      = XW'(wpos);
					lw_wr[k]  = 1'b1;
					lw_idx[k] = wext[7:0];
					lw_ch[k]  = raw_c[k];
					wpos      = wpos + POS_W'(1);
					lw_n      = lw_n + 2'd1;
				end
			end
		end
	end

	// Header grammar: one byte of "PD,id,len".
	always_comb begin
		digit    = (c >= atipd_pkg::CH_ZERO) && (c <= atipd_pkg::CH_NINE);
		hp_phase = phase_q;
		hp_id    = id_q;
		hp_len   = len_q;
		id_acc   = ((phase_q == atipd_pkg::PH_ID0) ? 8'd0 : {4'd0, id_q}) * 8'd10 +
		           {4'd0, c[3:0]};
		len_acc  = ((phase_q == atipd_pkg::PH_LEN0) ? 16'd0 : {4'd0, len_q}) * 16'd10 +
		           {12'd0, c[3:0]};
		case (phase_q) inside
			atipd_pkg::PH_P:   hp_phase = (c == atipd_pkg::CH_P) ? atipd_pkg::PH_D
			                                                     : atipd_pkg::PH_BAD;
			atipd_pkg::PH_D:   hp_phase = (c == atipd_pkg::CH_D) ? atipd_pkg::PH_SEP
			                                                     : atipd_pkg::PH_BAD;
			atipd_pkg::PH_SEP: hp_phase = (c == atipd_pkg::CH_COMMA) ? atipd_pkg::PH_ID0
			                                                         : atipd_pkg::PH_BAD;
			atipd_pkg::PH_ID0, atipd_pkg::PH_ID: begin
				if (digit) begin
					hp_id    = (id_acc > 8'd15) ? atipd_pkg::ID_MAX : id_acc[3:0];
					hp_phase = atipd_pkg::PH_ID;
				end else if (c == atipd_pkg::CH_COMMA && phase_q == atipd_pkg::PH_ID) begin
					hp_phase = atipd_pkg::PH_LEN0;
				end else begin
					hp_phase = atipd_pkg::PH_BAD;
				end
			end
			atipd_pkg::PH_LEN0, atipd_pkg::PH_LEN: begin
				if (digit) begin
					hp_len   = (len_acc > 16'd4095) ? atipd_pkg::LEN_MAX : len_acc[11:0];
					hp_phase = atipd_pkg::PH_LEN;
				end else begin
					hp_phase = atipd_pkg::PH_BAD;
				end
			end
			default: hp_phase = atipd_pkg::PH_BAD;
		endcase
	end

	assign cap      = ((id_q < CHAN_LIM) && (id_q < 4'(atipd_pkg::NUM_CAP))) ?
	                  cap_q[id_q[2:0]] : 12'd0;
	assign br_inc   = (br_q < atipd_pkg::BR_MAX) ? br_q + 13'd1 : br_q;
	assign pay_keep = br_inc <= {1'b0, cap};
	assign tc_inc   = (tc_q == atipd_pkg::TC_MAX) ? tc_q : tc_q + 16'd1;
	assign cnt_inc  = cnt_q + CNT_W'(1);

	// Next state and the status of this word.
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		id_d     = id_q;
		len_d    = len_q;
		br_d     = br_q;
		pos_d    = pos_q;
		tc_d     = tc_q;
		use_line = 1'b0;
		dw       = 1'b0;
		ls       = atipd_pkg::STAT_NONE;
		ds       = atipd_pkg::STAT_NONE;
		send     = 1'b0;
		if (in_word.opcode == atipd_pkg::OP_TICK) begin
			if (state_q == atipd_pkg::ST_IDLE) begin
				tc_d = 16'd0;
			end else if (tc_inc > tt_q) begin
				if (state_q == atipd_pkg::ST_LINE) ls = atipd_pkg::STAT_TMO;
				else ds = atipd_pkg::STAT_TMO;
				state_d = atipd_pkg::ST_IDLE;
				tc_d    = 16'd0;
			end else begin
				tc_d = tc_inc;
			end
		end else begin
			unique case (state_q)
				atipd_pkg::ST_IDLE: begin
					if (c == atipd_pkg::CH_PLUS) begin
						cnt_d   = '0;
						phase_d = atipd_pkg::PH_P;
						state_d = atipd_pkg::ST_HEADER;
					end else if (c == atipd_pkg::CH_GT) begin
						state_d = atipd_pkg::ST_PROMPT;
					end else begin
						use_line = 1'b1;
						pos_d    = wpos;
						if (lw_ok) begin
							state_d = atipd_pkg::ST_LINE;
						end else begin
							ls = atipd_pkg::STAT_OVF;
						end
					end
				end
				atipd_pkg::ST_LINE: begin
					if (c == atipd_pkg::CH_LF) begin
						ls      = atipd_pkg::STAT_DONE;
						state_d = atipd_pkg::ST_IDLE;
					end else begin
						use_line = 1'b1;
						pos_d    = wpos;
						if (!lw_ok) begin
							ls      = atipd_pkg::STAT_OVF;
							state_d = atipd_pkg::ST_IDLE;
						end
					end
				end
				atipd_pkg::ST_HEADER: begin
					if (hdr_restart) begin
						use_line = 1'b1;
						pos_d    = wpos;
						state_d  = atipd_pkg::ST_LINE;
					end else if (cnt_q == '0) begin
						cnt_d   = CNT_W'(1);
						phase_d = atipd_pkg::PH_P;
					end else begin
						cnt_d = cnt_inc;
						if (c == atipd_pkg::CH_COLON) begin
							if (phase_q == atipd_pkg::PH_LEN) begin
								br_d    = 13'd0;
								state_d = atipd_pkg::ST_PAYLOAD;
							end else begin
								ds      = atipd_pkg::STAT_OVF;
								state_d = atipd_pkg::ST_IDLE;
							end
						end else begin
							phase_d = hp_phase;
							id_d    = hp_id;
							len_d   = hp_len;
							if (cnt_inc >= HDR_LIM) begin
								ds      = atipd_pkg::STAT_OVF;
								state_d = atipd_pkg::ST_IDLE;
							end
						end
					end
				end
				atipd_pkg::ST_PAYLOAD: begin
					br_d = br_inc;
					dw   = pay_keep;
					if (br_inc == {1'b0, len_q}) begin
						ds      = pay_keep ? atipd_pkg::STAT_DONE : atipd_pkg::STAT_OVF;
						state_d = atipd_pkg::ST_IDLE;
					end
				end
				atipd_pkg::ST_PROMPT: begin
					send    = 1'b1;
					state_d = atipd_pkg::ST_IDLE;
				end
				default: state_d = atipd_pkg::ST_IDLE;
			endcase
		end
	end

	// Result bundle; statuses and the last mark go on the final result.
	always_comb begin
		bundle = '0;
		if (use_line) begin
			for (int k = 0; k < 3; k++) begin
				bundle.res[k].line_write = lw_wr[k];
				bundle.res[k].line_index = lw_idx[k];
				bundle.res[k].line_char  = lw_ch[k];
			end
			bundle.count = lw_n;
		end
		if (dw) begin
			bundle.res[0].data_write   = 1'b1;
			bundle.res[0].data_channel = id_q;
			bundle.res[0].data_offset  = br_inc[11:0] - 12'd1;
			bundle.res[0].data_byte    = c;
			bundle.count               = 2'd1;
		end
		if (bundle.count == 2'd0) bundle.count = 2'd1;
		fin = bundle.count - 2'd1;
		bundle.res[fin].line_status = ls;
		bundle.res[fin].data_status = ds;
		bundle.res[fin].send_now    = send;
		bundle.res[fin].last        = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tt_q <= atipd_pkg::TIMEOUT_RESET;
			for (int k = 0; k < atipd_pkg::NUM_CAP; k++) cap_q[k] <= 12'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				atipd_pkg::REG_TIMEOUT: tt_q     <= cfg_data;
				atipd_pkg::REG_CAP0:    cap_q[0] <= cfg_data[11:0];
				atipd_pkg::REG_CAP1:    cap_q[1] <= cfg_data[11:0];
				atipd_pkg::REG_CAP2:    cap_q[2] <= cfg_data[11:0];
				atipd_pkg::REG_CAP3:    cap_q[3] <= cfg_data[11:0];
				atipd_pkg::REG_CAP4:    cap_q[4] <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atipd_pkg::ST_IDLE;
			phase_q <= atipd_pkg::PH_P;
			cnt_q   <= '0;
			id_q    <= 4'd0;
			len_q   <= 12'd0;
			br_q    <= 13'd0;
			pos_q   <= '0;
			tc_q    <= 16'd0;
		end else if (push) begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			id_q    <= id_d;
			len_q   <= len_d;
			br_q    <= br_d;
			pos_q   <= pos_d;
			tc_q    <= tc_d;
		end
	end

endmodule

// ===== src/atipd_queue.sv =====
// Short queue of result bundles between the front and back ends.
// Depends on atipd_pkg.
module atipd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  atipd_pkg::bundle_t  push_data,
	input  logic                pop,
	output logic                full,
	output atipd_pkg::q_head_t  head
);

	localparam int D   = atipd_pkg::QUEUE_DEPTH;
	localparam int PW  = $clog2(D);
	localparam int CW  = $clog2(D + 1);

	atipd_pkg::bundle_t mem_q [D];
	logic [PW-1:0]      wr_q, rd_q;
	logic [CW-1:0]      cnt_q;

	assign full       = (cnt_q == CW'(D));
	assign head.valid = (cnt_q != '0);
	assign head.data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop)  rd_q <= rd_q + PW'(1);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== src/atipd_back.sv =====
// Back end: issues the results of each queued bundle one word at a time.
// Depends on atipd_pkg.
module atipd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  atipd_pkg::q_head_t   head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output atipd_pkg::out_word_t out_word
);

	logic                 valid_q;
	atipd_pkg::out_word_t word_q;
	logic [1:0]           sub_q;
	logic                 take;

	assign take      = !valid_q || !out_stall;
	assign pop       = take && head.valid && (sub_q == head.data.count - 2'd1);
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk) begin
		if (take && head.valid) word_q <= head.data.res[sub_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 2'd0;
		end else if (take) begin
			valid_q <= head.valid;
			if (pop) sub_q <= 2'd0;
			else if (head.valid) sub_q <= sub_q + 2'd1;
		end
	end

endmodule

// ===== src/atipd_checker.sv =====
// Port-level checks of the IPD response parser, bound to the top level.
// Depends on atipd_pkg, at_response_ipd_parser and the defines header.
`include "at_response_ipd_parser_defines.svh"

module atipd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input atipd_pkg::out_word_t out_word
);

	// A stalled result word is held unchanged.
	property p_out_hold;
		out_valid && out_stall |=> out_valid && $stable(out_word);
	endproperty

	// A result word stores into the line or into a channel, never both.
	property p_one_store;
		out_valid |-> !(out_word.line_write && out_word.data_write);
	endproperty

	// Statuses and the prompt pulse only ride on the last word of an input.
	property p_status_last;
		out_valid && (out_word.line_status != atipd_pkg::STAT_NONE ||
		              out_word.data_status != atipd_pkg::STAT_NONE ||
		              out_word.send_now) |-> out_word.last;
	endproperty

	// Line position and character read as zero without a line write.
	property p_line_zero;
		out_valid && !out_word.line_write |->
			out_word.line_index == 8'd0 && out_word.line_char == 8'd0;
	endproperty

	property p_reset_idle;
		!arst_n |-> !out_valid;
	endproperty

	`ATIPD_ASSERT(a_out_hold, p_out_hold, "stalled output word changed")
	`ATIPD_ASSERT(a_one_store, p_one_store, "line and data write in one word")
	`ATIPD_ASSERT(a_status_last, p_status_last, "status on a word that is not last")
	`ATIPD_ASSERT(a_line_zero, p_line_zero, "line fields set without a line write")
	`ATIPD_ASSERT_ALWAYS(a_reset_idle, p_reset_idle, "output valid during reset")

endmodule

bind at_response_ipd_parser atipd_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the modem IPD response parser.
// Depends on atipd_pkg and the at_response_ipd_parser top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	atipd_pkg::in_word_t in_word;
	logic out_valid;
	logic out_stall;
	atipd_pkg::out_word_t out_word;
	logic cfg_write;
	logic [atipd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [atipd_pkg::CFG_W-1:0] cfg_data;

	at_response_ipd_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Idle and stall rates in percent, and the long receiver hold-off.
	int send_idle_pct;
	int stall_pct;
	int hold_req;
	int hold_left;
	int mismatches;
	int cycles;

	// Results still owed by the parser, oldest first.
	atipd_pkg::out_word_t owed_q[$];

	// Shadow copy of the parser registers and state.
	logic [15:0]       tmo_ticks;
	logic [11:0]       cap_reg[atipd_pkg::NUM_CAP];
	atipd_pkg::state_t pst;
	logic [2:0]        hphase;
	logic [4:0]        hcount;
	logic [3:0]        lid;
	logic [11:0]       plen;
	logic [12:0]       brcv;
	logic [7:0]        lpos;
	logic [15:0]       tcnt;

	// Results of the word now being worked out.
	atipd_pkg::out_word_t pend[3];
	int npend;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The watchdog: a correct run ends well inside this many cycles.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("at_response_ipd_parser verification failed");
			$finish;
		end
	end

	// Receiver side. A requested hold-off keeps the output stalled for a long
	// stretch; otherwise the stall is drawn at the current rate.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		end
	end

	// Every accepted result word is compared with the oldest one owed.
	always @(posedge clk) begin
		atipd_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: expected none, got %p", out_word);
			end else begin
				want = owed_q.pop_front();
				if (out_word.line_write !== want.line_write ||
						out_word.line_index !== want.line_index ||
						out_word.line_char !== want.line_char ||
						out_word.line_status !== want.line_status ||
						out_word.data_write !== want.data_write ||
						out_word.data_channel !== want.data_channel ||
						out_word.data_offset !== want.data_offset ||
						out_word.data_byte !== want.data_byte ||
						out_word.data_status !== want.data_status ||
						out_word.send_now !== want.send_now ||
						out_word.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, out_word);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Parser model
	// ---------------------------------------------------------------------

	// Opens a further result word; a fourth one would fold onto the third.
	function automatic int open_result();
		if (npend >= 3)
			return 2;
		pend[npend] = '0;
		npend++;
		return npend - 1;
	endfunction

	function automatic int final_result();
		if (npend == 0)
			return open_result();
		return npend - 1;
	endfunction

	// Writes one character to the line store, unless the store is full.
	function automatic bit store_char(logic [7:0] ch);
		int k;
		if (int'(lpos) + 1 >= atipd_pkg::LINE_DEPTH_DEF)
			return 1'b0;
		k = open_result();
		pend[k].line_write = 1'b1;
		pend[k].line_index = lpos;
		pend[k].line_char = ch;
		lpos++;
		return 1'b1;
	endfunction

	// CR and LF are dropped and a NUL becomes backslash and zero.
	function automatic bit line_char_in(logic [7:0] c);
		if (c == atipd_pkg::CH_NUL)
			return store_char(atipd_pkg::CH_BSL) && store_char(atipd_pkg::CH_ZERO);
		if (c == atipd_pkg::CH_CR || c == atipd_pkg::CH_LF)
			return 1'b1;
		return store_char(c);
	endfunction

	// One byte of the header after the "+I"; phases follow "PD,id,len".
	function automatic void header_step(logic [7:0] c);
		bit digit;
		int acc;
		digit = (c >= atipd_pkg::CH_ZERO && c <= atipd_pkg::CH_NINE);
		case (hphase)
			atipd_pkg::PH_P:
				hphase = (c == atipd_pkg::CH_P) ? atipd_pkg::PH_D : atipd_pkg::PH_BAD;
			atipd_pkg::PH_D:
				hphase = (c == atipd_pkg::CH_D) ? atipd_pkg::PH_SEP : atipd_pkg::PH_BAD;
			atipd_pkg::PH_SEP:
				hphase = (c == atipd_pkg::CH_COMMA) ? atipd_pkg::PH_ID0 : atipd_pkg::PH_BAD;
			atipd_pkg::PH_ID0, atipd_pkg::PH_ID: begin
				if (digit) begin
					acc = (hphase == atipd_pkg::PH_ID0) ? 0 : int'(lid);
					acc = acc * 10 + int'(c - atipd_pkg::CH_ZERO);
					lid = (acc > int'(atipd_pkg::ID_MAX)) ? atipd_pkg::ID_MAX : acc[3:0];
					hphase = atipd_pkg::PH_ID;
				end else if (c == atipd_pkg::CH_COMMA && hphase == atipd_pkg::PH_ID) begin
					hphase = atipd_pkg::PH_LEN0;
				end else begin
					hphase = atipd_pkg::PH_BAD;
				end
			end
			atipd_pkg::PH_LEN0, atipd_pkg::PH_LEN: begin
				if (digit) begin
					acc = (hphase == atipd_pkg::PH_LEN0) ? 0 : int'(plen);
					acc = acc * 10 + int'(c - atipd_pkg::CH_ZERO);
					plen = (acc > int'(atipd_pkg::LEN_MAX)) ? atipd_pkg::LEN_MAX : acc[11:0];
					hphase = atipd_pkg::PH_LEN;
				end else begin
					hphase = atipd_pkg::PH_BAD;
				end
			end
			default: hphase = atipd_pkg::PH_BAD;
		endcase
	endfunction

	function automatic void byte_step(logic [7:0] c);
		int k;
		logic [11:0] cap;
		bit ok;
		case (pst)
			atipd_pkg::ST_IDLE: begin
				if (c == atipd_pkg::CH_PLUS) begin
					hcount = '0;
					hphase = atipd_pkg::PH_P;
					pst = atipd_pkg::ST_HEADER;
				end else if (c == atipd_pkg::CH_GT) begin
					pst = atipd_pkg::ST_PROMPT;
				end else begin
					lpos = '0;
					if (line_char_in(c)) begin
						pst = atipd_pkg::ST_LINE;
					end else begin
						pend[final_result()].line_status = atipd_pkg::STAT_OVF;
						pst = atipd_pkg::ST_IDLE;
					end
				end
			end
			atipd_pkg::ST_LINE: begin
				if (c == atipd_pkg::CH_LF) begin
					pend[final_result()].line_status = atipd_pkg::STAT_DONE;
					pst = atipd_pkg::ST_IDLE;
				end else if (!line_char_in(c)) begin
					pend[final_result()].line_status = atipd_pkg::STAT_OVF;
					pst = atipd_pkg::ST_IDLE;
				end
			end
			atipd_pkg::ST_HEADER: begin
				if (hcount == 0 && c != atipd_pkg::CH_I) begin
					// Not a header after all: the line restarts with the plus.
					lpos = '0;
					ok = line_char_in(atipd_pkg::CH_PLUS);
					ok = line_char_in(c);
					pst = atipd_pkg::ST_LINE;
				end else if (hcount == 0) begin
					hcount = 5'd1;
					hphase = atipd_pkg::PH_P;
				end else begin
					hcount++;
					if (c == atipd_pkg::CH_COLON) begin
						if (hphase == atipd_pkg::PH_LEN) begin
							brcv = '0;
							pst = atipd_pkg::ST_PAYLOAD;
						end else begin
							pend[final_result()].data_status = atipd_pkg::STAT_OVF;
							pst = atipd_pkg::ST_IDLE;
						end
					end else begin
						header_step(c);
						if (int'(hcount) >= atipd_pkg::HEADER_DEPTH_DEF) begin
							pend[final_result()].data_status = atipd_pkg::STAT_OVF;
							pst = atipd_pkg::ST_IDLE;
						end
					end
				end
			end
			atipd_pkg::ST_PAYLOAD: begin
				cap = (int'(lid) < atipd_pkg::CHANNELS_DEF && int'(lid) < atipd_pkg::NUM_CAP) ?
					cap_reg[lid] : 12'd0;
				if (brcv < atipd_pkg::BR_MAX)
					brcv++;
				if (brcv <= {1'b0, cap}) begin
					k = open_result();
					pend[k].data_write = 1'b1;
					pend[k].data_channel = lid;
					pend[k].data_offset = brcv[11:0] - 12'd1;
					pend[k].data_byte = c;
				end
				if (brcv == {1'b0, plen}) begin
					pend[final_result()].data_status =
						(brcv <= {1'b0, cap}) ? atipd_pkg::STAT_DONE : atipd_pkg::STAT_OVF;
					pst = atipd_pkg::ST_IDLE;
				end
			end
			atipd_pkg::ST_PROMPT: begin
				pend[final_result()].send_now = 1'b1;
				pst = atipd_pkg::ST_IDLE;
			end
			default: pst = atipd_pkg::ST_IDLE;
		endcase
	endfunction

	function automatic void tick_step();
		if (pst == atipd_pkg::ST_IDLE) begin
			tcnt = '0;
			return;
		end
		if (tcnt < atipd_pkg::TC_MAX)
			tcnt++;
		if (tcnt > tmo_ticks) begin
			if (pst == atipd_pkg::ST_LINE)
				pend[final_result()].line_status = atipd_pkg::STAT_TMO;
			else
				pend[final_result()].data_status = atipd_pkg::STAT_TMO;
			pst = atipd_pkg::ST_IDLE;
			tcnt = '0;
		end
	endfunction

	// Works out the results of one accepted word and adds them to the owed list.
	function automatic void predict_results(atipd_pkg::in_word_t w);
		npend = 0;
		if (w.opcode == atipd_pkg::OP_TICK)
			tick_step();
		else
			byte_step(w.rx_byte);
		pend[final_result()].last = 1'b1;
		for (int i = 0; i < npend; i++)
			owed_q.push_back(pend[i]);
	endfunction

	// ---------------------------------------------------------------------
	// Shared driving tasks
	// ---------------------------------------------------------------------

	// Offers one word, after a random gap at the sender's idle rate, and waits
	// until the parser takes it. valid stays high between back-to-back words.
	task automatic send_word(logic op, logic [7:0] b);
		atipd_pkg::in_word_t w;
		w.opcode = op;
		w.rx_byte = b;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (in_stall);
		predict_results(w);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_word(atipd_pkg::OP_BYTE, b);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_ticks(int n);
		for (int i = 0; i < n; i++)
			send_word(atipd_pkg::OP_TICK, 8'($urandom));
	endtask

	// Stops offering words and waits until every owed result has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (owed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes happen only with the parser drained.
	task automatic write_reg(logic [atipd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == atipd_pkg::REG_TIMEOUT)
			tmo_ticks = val;
		else
			cap_reg[idx - atipd_pkg::REG_CAP0] = val[11:0];
	endtask

	task automatic send_packet(int id, int len, int extra);
		send_text($sformatf("+IPD,%0d,%0d:", id, len));
		for (int i = 0; i < len + extra; i++)
			send_byte(8'($urandom));
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Default registers: every channel has zero capacity, timeout 5000.
	task automatic test_reset_values();
		send_ticks(1);
		send_packet(4, 1, 0);
		drain();
	endtask

	task automatic test_text_lines();
		write_reg(atipd_pkg::REG_TIMEOUT, 16'd40);
		send_text("OK\r\n");
		// A plus not followed by I restarts as a line, NUL escaping included.
		send_text("+X\n");
		send_byte(atipd_pkg::CH_PLUS);
		send_byte(atipd_pkg::CH_NUL);
		send_byte(atipd_pkg::CH_LF);
		drain();
	endtask

	task automatic test_headers();
		write_reg(atipd_pkg::REG_CAP0, 16'd4095);
		write_reg(atipd_pkg::REG_CAP1, 16'd2);
		write_reg(atipd_pkg::REG_CAP2, 16'd0);
		write_reg(atipd_pkg::REG_CAP3, 16'd3);
		write_reg(atipd_pkg::REG_CAP4, 16'd5);
		// More payload than the channel holds.
		send_packet(1, 3, 0);
		// Id and length both saturate; the payload is left to time out.
		send_text("+IPD,99,99999:");
		send_byte(8'($urandom));
		drain();
		write_reg(atipd_pkg::REG_TIMEOUT, 16'd0);
		send_ticks(1);
		// Missing length, then a header that runs too long without a colon.
		send_text("+IPD,3:");
		send_text("+IPD,1,00000000000000");
		drain();
	endtask

	task automatic test_prompt();
		send_byte(atipd_pkg::CH_GT);
		send_byte(atipd_pkg::CH_LF);
		send_byte(atipd_pkg::CH_GT);
		send_byte(atipd_pkg::CH_GT);
		send_byte(atipd_pkg::CH_GT);
		send_byte(atipd_pkg::CH_NUL);
		drain();
	endtask

	task automatic test_timeouts();
		write_reg(atipd_pkg::REG_TIMEOUT, 16'd1);
		send_ticks(1);
		send_text("ab");
		send_ticks(2);
		send_text("+I");
		send_ticks(2);
		send_byte(atipd_pkg::CH_GT);
		send_ticks(2);
		write_reg(atipd_pkg::REG_TIMEOUT, 16'hFFFF);
		send_text("x");
		send_ticks(3);
		send_byte(atipd_pkg::CH_LF);
		drain();
	endtask

	// NULs fill the line store two characters at a time until it overflows,
	// the last one with only its backslash written.
	task automatic test_line_overflow();
		for (int i = 0; i < 128; i++)
			send_byte(atipd_pkg::CH_NUL);
		drain();
	endtask

	// One random sequence, mostly well-formed with random content.
	task automatic random_sequence();
		int kind;
		int n;
		logic [7:0] b;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3: begin
				n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
				send_packet($urandom_range(0, 6), n, (n == 0) ? 2 : 0);
				if (n == 0)
					send_ticks(int'(tmo_ticks) + 1);
			end
			4, 5: begin
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) begin
					b = 8'($urandom);
					send_byte(b);
				end
				send_byte(atipd_pkg::CH_LF);
			end
			6: begin
				send_byte(atipd_pkg::CH_GT);
				send_byte(8'($urandom));
			end
			7: begin
				send_text("+IPD,");
				send_byte(8'($urandom));
				send_text("1:");
			end
			8: send_ticks($urandom_range(1, 4));
			default: send_word(1'($urandom), 8'($urandom));
		endcase
	endtask

	task automatic test_random_phase(int idle_pct, int stall, int seqs);
		write_reg(atipd_pkg::REG_TIMEOUT, 16'($urandom_range(0, 6)));
		for (int i = 0; i < atipd_pkg::NUM_CAP; i++)
			write_reg(atipd_pkg::REG_CAP0 + 3'(i), 16'($urandom_range(0, 6)));
		send_idle_pct = idle_pct;
		stall_pct = stall;
		for (int i = 0; i < seqs; i++)
			random_sequence();
		drain();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	// The receiver holds off while words keep coming, so the queue fills
	// and the input is stalled.
	task automatic test_backpressure();
		write_reg(atipd_pkg::REG_TIMEOUT, 16'd2);
		hold_req = 300;
		send_packet(0, 3, 0);
		random_sequence();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		mismatches = 0;
		cycles = 0;
		tmo_ticks = atipd_pkg::TIMEOUT_RESET;
		for (int i = 0; i < atipd_pkg::NUM_CAP; i++)
			cap_reg[i] = '0;
		pst = atipd_pkg::ST_IDLE;
		hphase = atipd_pkg::PH_P;
		hcount = '0;
		lid = '0;
		plen = '0;
		brcv = '0;
		lpos = '0;
		tcnt = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_text_lines();
		test_headers();
		test_prompt();
		test_timeouts();
		test_line_overflow();
		test_random_phase(0, 0, 2);
		test_random_phase(85, 0, 2);
		test_random_phase(0, 85, 2);
		test_random_phase(19, 19, 2);
		test_backpressure();

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && owed_q.size() == 0) begin
			$display("at_response_ipd_parser verification clean");
		end else begin
			$display("at_response_ipd_parser verification failed");
		end
		$finish;
	end

endmodule
